### design/deque_with_positional_insert_unit_macros.svh
// Assertion macros used by the deque top-level design file.
`ifndef DEQUE_WITH_POSITIONAL_INSERT_UNIT_MACROS_SVH
`define DEQUE_WITH_POSITIONAL_INSERT_UNIT_MACROS_SVH

// Implication checked on every clock edge, masked while reset is held.
`define DQPI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must hold on every clock edge, masked while reset is held.
`define DQPI_ASSERT_ALWAYS(label, expr, msg) \
    `DQPI_ASSERT(label, 1'b1 |-> (expr), msg)

`endif

### design/dqpi_pkg.sv
// Package: command codes, status codes and sizes of the deque.
package dqpi_pkg;

    // Sizes
    localparam int DEPTH_DEF = 64;
    localparam int VALUE_W   = 32;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

endpackage

### design/dqpi_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module dqpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/deque_with_positional_insert_unit.sv
// Top level: bounded double-ended queue of signed 32-bit values with positional insert.
// Bounded deque of DEPTH signed 32-bit values held in a circular buffer in one
// simple dual-port RAM; each command word yields exactly one result word.
// Push front, push back, insert at either end, pop front, pop back, clear,
// unknown codes and every error case go through the accept state (which also
// issues the RAM read for a pop) and the execute state. An insert strictly
// inside the queue at position p with n values held then goes through a
// shift state, where the single RAM write port moves one entry toward the back
// per cycle (n - p entries) before the new value is written. The result sits
// in an output register, so the next command word is taken while an earlier
// result waits. The RAM needs no clearing pass after reset: only held data is ever used.
module deque_with_positional_insert_unit #(
    parameter int DEPTH = dqpi_pkg::DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Command word
    input  logic                                                 s_axis_tvalid,
    output logic                                                 s_axis_tready,
    // [31:0] item_value, then position, zero padding above
    input  logic [((dqpi_pkg::VALUE_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // [2:0] command
    input  logic [dqpi_pkg::CMD_W-1:0]                           s_axis_tuser,
    // Result word
    output logic                                                 m_axis_tvalid,
    input  logic                                                 m_axis_tready,
    // [31:0] popped_value, then entries_held, zero padding above
    output logic [((dqpi_pkg::VALUE_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // [1:0] status
    output logic [dqpi_pkg::STAT_W-1:0]                          m_axis_tuser
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int VW   = dqpi_pkg::VALUE_W;
    localparam int DW   = ((VW + CW + 7) / 8) * 8;
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_INSW  = 2'd3;

    // Circular slot of an offset from a given front
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    logic [1:0]                 r_state, n_state;
    logic [dqpi_pkg::CMD_W-1:0] r_cmd;
    logic [VW-1:0]              r_val;
    logic [CW-1:0]              r_pos;
    logic [AW-1:0]              r_front, n_front;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_idx, n_idx;
    logic                       r_out_valid, n_out_valid;
    logic [VW-1:0]              r_out_pop, n_out_pop;
    logic [dqpi_pkg::STAT_W-1:0] r_out_stat, n_out_stat;
    logic [CW-1:0]              r_out_cnt, n_out_cnt;

    logic          in_acc;
    logic          out_free;
    logic [CW-1:0] eff_pos;
    logic [AW-1:0] front_m1;
    logic [AW-1:0] back_slot;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [VW-1:0] wr_data, rd_data;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign front_m1      = (r_front == '0) ? LAST_A : r_front - 1'b1;
    assign back_slot     = slot_of(r_front, r_count - 1'b1);

    // Effective insert position for the three push-type commands
    always_comb begin
        case (r_cmd)
            dqpi_pkg::CMD_PUSH_BACK:  eff_pos = r_count;
            dqpi_pkg::CMD_PUSH_FRONT: eff_pos = '0;
            default:                  eff_pos = r_pos;
        endcase
    end

    // Sequencer, queue pointers, RAM port control and result load
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_pop   = r_out_pop;
        n_out_stat  = r_out_stat;
        n_out_cnt   = r_out_cnt;
        wr_en       = 1'b0;
        wr_addr     = r_front;
        wr_data     = r_val;
        rd_en       = 1'b0;
        rd_addr     = r_front;

        unique case (r_state)
            S_IDLE: begin
                // Pop data is fetched while the word is taken
                if (in_acc) begin
                    rd_en   = 1'b1;
                    rd_addr = (s_axis_tuser == dqpi_pkg::CMD_POP_FRONT) ? r_front : back_slot;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_pop   = '0;
                    n_out_stat  = dqpi_pkg::ST_DONE;
                    case (r_cmd)
                        dqpi_pkg::CMD_PUSH_BACK, dqpi_pkg::CMD_PUSH_FRONT,
                        dqpi_pkg::CMD_INSERT: begin
                            if (eff_pos > r_count) begin
                                n_out_stat = dqpi_pkg::ST_RANGE;
                            end else if (r_count == DEPTH_C) begin
                                n_out_stat = dqpi_pkg::ST_FULL;
                            end else if (eff_pos == '0) begin
                                wr_en   = 1'b1;
                                wr_addr = front_m1;
                                n_front = front_m1;
                                n_count = r_count + 1'b1;
                            end else if (eff_pos == r_count) begin
                                wr_en   = 1'b1;
                                wr_addr = slot_of(r_front, r_count);
                                n_count = r_count + 1'b1;
                            end else begin
                                // Middle insert: move the tail up one entry at a time
                                n_out_valid = r_out_valid && !m_axis_tready;
                                rd_en       = 1'b1;
                                rd_addr     = back_slot;
                                n_idx       = r_count;
                                n_state     = S_SHIFT;
                            end
                        end
                        dqpi_pkg::CMD_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_out_stat = dqpi_pkg::ST_EMPTY;
                            end else begin
                                n_out_pop = rd_data;
                                n_front   = (r_front == LAST_A) ? '0 : r_front + 1'b1;
                                n_count   = r_count - 1'b1;
                            end
                        end
                        dqpi_pkg::CMD_POP_BACK: begin
                            if (r_count == '0) begin
                                n_out_stat = dqpi_pkg::ST_EMPTY;
                            end else begin
                                n_out_pop = rd_data;
                                n_count   = r_count - 1'b1;
                            end
                        end
                        dqpi_pkg::CMD_CLEAR: begin
                            n_front = '0;
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_out_cnt = n_count;
                end
            end
            S_SHIFT: begin
                // Entry read last cycle goes one slot toward the back
                wr_en   = 1'b1;
                wr_addr = slot_of(r_front, r_idx);
                wr_data = rd_data;
                if (r_idx == r_pos + 1'b1) begin
                    n_state = S_INSW;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = slot_of(r_front, r_idx - 2'd2);
                    n_idx   = r_idx - 1'b1;
                end
            end
            S_INSW: begin
                // New value lands in the freed slot
                if (out_free) begin
                    wr_en       = 1'b1;
                    wr_addr     = slot_of(r_front, r_pos);
                    n_count     = r_count + 1'b1;
                    n_out_valid = 1'b1;
                    n_out_pop   = '0;
                    n_out_stat  = dqpi_pkg::ST_DONE;
                    n_out_cnt   = r_count + 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Command and result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd <= s_axis_tuser;
            r_val <= s_axis_tdata[VW-1:0];
            r_pos <= s_axis_tdata[VW+CW-1:VW];
        end
        r_out_pop  <= n_out_pop;
        r_out_stat <= n_out_stat;
        r_out_cnt  <= n_out_cnt;
    end

    // Entry store
    dqpi_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = DW'({r_out_cnt, r_out_pop});
    assign m_axis_tuser  = r_out_stat;

`include "deque_with_positional_insert_unit_macros.svh"

    `DQPI_ASSERT_ALWAYS(a_count_bound, r_count <= DEPTH_C, "held count above depth")
    `DQPI_ASSERT_ALWAYS(a_idle_no_write, !(r_state == S_IDLE && wr_en), "RAM write while idle")
    `DQPI_ASSERT(a_shift_range, r_state == S_SHIFT |-> (r_idx > r_pos && r_idx <= r_count), "shift index out of range")
    `DQPI_ASSERT(a_accept_exec, in_acc |=> r_state == S_EXEC, "accepted word not executed")

endmodule

### tb/tb_top.sv
// Testbench for the deque unit: queue-based predictor, stream driver and result checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH   = dqpi_pkg::DEPTH_DEF;
    localparam int VALUE_W = dqpi_pkg::VALUE_W;
    localparam int CMD_W   = dqpi_pkg::CMD_W;
    localparam int STAT_W  = dqpi_pkg::STAT_W;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TDATA_W = ((VALUE_W + CNT_W + 7) / 8) * 8;
    // Codes outside the command set; the unit treats them as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam int RAND_WORDS = 1600;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   pos;
    } t_cmd_word;

    typedef struct packed {
        logic [VALUE_W-1:0] popped;
        logic [STAT_W-1:0]  status;
        logic [CNT_W-1:0]   held;
    } t_deque_result;

    typedef enum int {FILL_UP, DRAIN_DOWN, MIXED} t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;   // [31:0] item_value, [38:32] position
    logic [CMD_W-1:0]   s_axis_tuser = '0;   // [2:0] command
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // [31:0] popped_value, [38:32] entries_held
    logic [STAT_W-1:0]  m_axis_tuser;        // [1:0] status

    // Predicted deque contents, front at index 0
    logic [VALUE_W-1:0] deque_contents[$];
    t_cmd_word          cmd_words[$];
    t_deque_result      results_due[$];

    bit steady = 1'b0;
    int errors = 0;
    int words_sent = 0;
    int words_done = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int peak_held = 0;
    int stall_cycles = 0;

    deque_with_positional_insert_unit #(.DEPTH(DEPTH)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Deque behavior: apply one command word, return the result it yields
    function automatic t_deque_result apply_command(t_cmd_word w);
        t_deque_result r;
        int unsigned   at;
        r = '{popped: '0, status: dqpi_pkg::ST_DONE, held: '0};
        case (w.cmd)
            dqpi_pkg::CMD_PUSH_BACK, dqpi_pkg::CMD_PUSH_FRONT, dqpi_pkg::CMD_INSERT: begin
                if (w.cmd == dqpi_pkg::CMD_PUSH_BACK)
                    at = deque_contents.size();
                else if (w.cmd == dqpi_pkg::CMD_PUSH_FRONT)
                    at = 0;
                else
                    at = 32'(w.pos);
                // range check wins over the full check
                if (at > deque_contents.size())
                    r.status = dqpi_pkg::ST_RANGE;
                else if (deque_contents.size() >= DEPTH)
                    r.status = dqpi_pkg::ST_FULL;
                else
                    deque_contents.insert(at, w.value);
            end
            dqpi_pkg::CMD_POP_FRONT: begin
                if (deque_contents.size() == 0)
                    r.status = dqpi_pkg::ST_EMPTY;
                else
                    r.popped = deque_contents.pop_front();
            end
            dqpi_pkg::CMD_POP_BACK: begin
                if (deque_contents.size() == 0)
                    r.status = dqpi_pkg::ST_EMPTY;
                else
                    r.popped = deque_contents.pop_back();
            end
            dqpi_pkg::CMD_CLEAR: deque_contents.delete();
            default: ;
        endcase
        r.held = CNT_W'(deque_contents.size());
        return r;
    endfunction

    // Sender: present the next pending word, idling at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (cmd_words.size() > 0 && (steady || $urandom_range(0, 99) >= 24)) begin
                t_cmd_word w;
                w = cmd_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(TDATA_W - VALUE_W - CNT_W){1'b0}}, w.pos, w.value};
                s_axis_tuser  <= w.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 24);
    end

    // Predict on every accepted command word
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_cmd_word w;
            w.cmd   = s_axis_tuser;
            w.value = s_axis_tdata[VALUE_W-1:0];
            w.pos   = s_axis_tdata[VALUE_W +: CNT_W];
            results_due.push_back(apply_command(w));
            if (deque_contents.size() > peak_held)
                peak_held = deque_contents.size();
        end
    end

    // Check every accepted result word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_deque_result want;
            logic [VALUE_W-1:0] got_popped;
            logic [CNT_W-1:0]   got_held;
            got_popped = m_axis_tdata[VALUE_W-1:0];
            got_held   = m_axis_tdata[VALUE_W +: CNT_W];
            words_done++;
            status_seen[m_axis_tuser]++;
            if (results_due.size() == 0) begin
                $error("unexpected result word: popped_value %0d status %0d entries_held %0d",
                       $signed(got_popped), m_axis_tuser, got_held);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (got_popped !== want.popped) begin
                    $error("popped_value: expected %0d, got %0d",
                           $signed(want.popped), $signed(got_popped));
                    errors++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    errors++;
                end
                if (got_held !== want.held) begin
                    $error("entries_held: expected %0d, got %0d", want.held, got_held);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles in a row with no word moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $error("no word moved for %0d cycles, %0d results outstanding",
                   STALL_LIMIT, results_due.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Hand one word to the sender, keeping the pending list short
    task automatic queue_word(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                              logic [CNT_W-1:0] pos);
        @(negedge i_clk);
        while (cmd_words.size() >= 2)
            @(negedge i_clk);
        cmd_words.push_back('{cmd: cmd, value: value, pos: pos});
        words_sent++;
    endtask

    // Wait until every pending word is sent and every result is back
    task automatic wait_quiet();
        while (cmd_words.size() != 0 || s_axis_tvalid || results_due.size() != 0)
            @(negedge i_clk);
    endtask

    // One random word, weighted by the phase
    task automatic random_word(t_phase phase);
        int unsigned        pick;
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   pos;
        pick  = $urandom_range(0, 99);
        value = $urandom;
        if ($urandom_range(0, 15) == 0)
            value = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        pos = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
        case (phase)
            FILL_UP: begin
                if (pick < 35)      cmd = dqpi_pkg::CMD_PUSH_BACK;
                else if (pick < 60) cmd = dqpi_pkg::CMD_PUSH_FRONT;
                else if (pick < 92) cmd = dqpi_pkg::CMD_INSERT;
                else if (pick < 96) cmd = dqpi_pkg::CMD_POP_FRONT;
                else                cmd = dqpi_pkg::CMD_POP_BACK;
            end
            DRAIN_DOWN: begin
                if (pick < 42)      cmd = dqpi_pkg::CMD_POP_FRONT;
                else if (pick < 84) cmd = dqpi_pkg::CMD_POP_BACK;
                else if (pick < 90) cmd = dqpi_pkg::CMD_INSERT;
                else if (pick < 95) cmd = dqpi_pkg::CMD_PUSH_BACK;
                else                cmd = dqpi_pkg::CMD_PUSH_FRONT;
            end
            default: begin
                if (pick < 18)      cmd = dqpi_pkg::CMD_PUSH_BACK;
                else if (pick < 34) cmd = dqpi_pkg::CMD_PUSH_FRONT;
                else if (pick < 56) cmd = dqpi_pkg::CMD_INSERT;
                else if (pick < 75) cmd = dqpi_pkg::CMD_POP_FRONT;
                else if (pick < 94) cmd = dqpi_pkg::CMD_POP_BACK;
                else if (pick < 96) cmd = dqpi_pkg::CMD_CLEAR;
                else if (pick < 98) cmd = CMD_SPARE_6;
                else                cmd = CMD_SPARE_7;
            end
        endcase
        // insert positions mostly near the live range, the odd one anywhere
        if (cmd == dqpi_pkg::CMD_INSERT && $urandom_range(0, 99) < 88)
            pos = CNT_W'($urandom_range(0, deque_contents.size() + 1));
        queue_word(cmd, value, pos);
    endtask

    // Stimulus: directed cases, then rounds of fill / drain / mixed traffic
    initial begin
        int round;
        int target;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty-queue corners and insert positions at, inside and past the ends
        queue_word(dqpi_pkg::CMD_POP_FRONT,  32'h0000_0000, 7'd0);
        queue_word(dqpi_pkg::CMD_POP_BACK,   32'hffff_ffff, 7'd127);
        queue_word(dqpi_pkg::CMD_INSERT,     32'h1234_5678, 7'd1);
        queue_word(dqpi_pkg::CMD_INSERT,     32'h1234_5678, 7'd127);
        queue_word(dqpi_pkg::CMD_INSERT,     32'h0000_0011, 7'd0);
        queue_word(dqpi_pkg::CMD_PUSH_BACK,  32'h7fff_ffff, 7'd0);
        queue_word(dqpi_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 7'd127);
        queue_word(dqpi_pkg::CMD_INSERT,     32'h0000_0022, 7'd3);
        queue_word(dqpi_pkg::CMD_INSERT,     32'hdead_beef, 7'd2);
        queue_word(dqpi_pkg::CMD_INSERT,     32'h0000_0033, 7'd6);
        queue_word(CMD_SPARE_6,              32'hffff_ffff, 7'd64);
        queue_word(CMD_SPARE_7,              32'h5555_5555, 7'd0);
        queue_word(dqpi_pkg::CMD_POP_FRONT,  32'haaaa_aaaa, 7'd0);
        queue_word(dqpi_pkg::CMD_POP_BACK,   32'h0000_0000, 7'd0);
        queue_word(dqpi_pkg::CMD_INSERT,     32'hffff_ffff, 7'd1);
        queue_word(dqpi_pkg::CMD_CLEAR,      32'h0000_0000, 7'd0);
        queue_word(dqpi_pkg::CMD_POP_FRONT,  32'h0000_0000, 7'd0);
        queue_word(dqpi_pkg::CMD_PUSH_BACK,  32'hffff_ffff, 7'd0);
        queue_word(dqpi_pkg::CMD_POP_BACK,   32'h0000_0000, 7'd0);
        queue_word(dqpi_pkg::CMD_POP_FRONT,  32'h0000_0000, 7'd0);
        queue_word(dqpi_pkg::CMD_INSERT,     32'h0000_0001, 7'd64);
        queue_word(dqpi_pkg::CMD_PUSH_FRONT, 32'h0000_0002, 7'd0);
        queue_word(dqpi_pkg::CMD_POP_FRONT,  32'h0000_0000, 7'd0);

        target = words_sent + RAND_WORDS;
        round = 0;
        while (words_sent < target) begin
            // let the unit drain completely before each round
            wait_quiet();
            steady = (round == 1);
            while (deque_contents.size() < DEPTH && words_sent < target)
                random_word(FILL_UP);
            // mostly pushes and inserts against a full queue
            repeat (6) random_word(FILL_UP);
            while (deque_contents.size() > 0 && words_sent < target)
                random_word(DRAIN_DOWN);
            repeat (4) random_word(DRAIN_DOWN);
            repeat (150) random_word(MIXED);
            round++;
        end
        steady = 1'b0;

        wait_quiet();
        repeat (100) @(negedge i_clk);
        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            errors++;
        end
        $display("Ran %0d command words in %0d rounds, %0d results checked, peak fill %0d of %0d.",
                 words_sent, round, words_done, peak_held, DEPTH);
        $display("Status counts: done %0d, empty %0d, full %0d, out of range %0d.",
                 status_seen[dqpi_pkg::ST_DONE], status_seen[dqpi_pkg::ST_EMPTY],
                 status_seen[dqpi_pkg::ST_FULL], status_seen[dqpi_pkg::ST_RANGE]);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
